/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge, off during reset
`define ASSERT_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Condition that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant failed");
`endif

/* hdl/brdp_pkg.sv */
// Package: codes and constants of the region decoder
`default_nettype none
package brdp_pkg;
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_MAP   = 2'd2;

  localparam logic [2:0] KIND_ALIAS = 3'd3;
  localparam logic [2:0] KIND_MMIO  = 3'd4;
  localparam logic [2:0] KIND_MAX   = 3'd4;

  localparam logic [3:0] F_OK        = 4'd0;
  localparam logic [3:0] F_WRAP      = 4'd1;
  localparam logic [3:0] F_UNMAPPED  = 4'd2;
  localparam logic [3:0] F_CROSS     = 4'd3;
  localparam logic [3:0] F_RPROT     = 4'd4;
  localparam logic [3:0] F_WPROT     = 4'd5;
  localparam logic [3:0] F_XPROT     = 4'd6;
  localparam logic [3:0] F_LOOP      = 4'd7;
  localparam logic [3:0] F_MMIO      = 4'd8;
  localparam logic [3:0] F_BADRANGE  = 4'd9;
  localparam logic [3:0] F_OVERLAP   = 4'd10;
  localparam logic [3:0] F_FULL      = 4'd11;
  localparam logic [3:0] F_BADALIAS  = 4'd12;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [1:0]  access_size;
    logic        ifetch;
    logic [31:0] region_size;
    logic [2:0]  region_kind;
    logic [2:0]  region_perms;
    logic [31:0] alias_dest;
  } req_t;

  typedef struct packed {
    logic [3:0]  fault;
    logic [3:0]  region_index;
    logic [31:0] offset;
    logic [2:0]  final_kind;
  } rsp_t;
endpackage
`default_nettype wire

/* hdl/brdp_if.sv */
// Valid/ready channel interfaces for request, response and configuration
`default_nettype none
interface brdp_req_if import brdp_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brdp_rsp_if import brdp_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brdp_cfg_if ();
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/bus_region_decoder_with_protection_top.sv */
// Top level: region decoder with protection checks, iterative slot scan
//
// channel  dir  payload
// req      in   opcode, address, access_size, ifetch, region_*, alias_dest
// rsp      out  fault, region_index, offset, final_kind
// cfg      in   trap_all_mmio
//
// One shared compare unit examines one table slot per cycle.
// Access: a slot scan (S_ACC) and a check (S_CHK) per lookup, up to MAX_ALIAS_DEPTH+1
// lookups, between the accept in S_IDLE and the response in S_RESP.
// Map: target scan for an alias, then overlap scan with free slot search.
// Reset clears the valid bits and the sequencer; the table holds no reset.
// A stalled response holds the block busy; no new request is taken.
`default_nettype none
`include "assert_macros.svh"
module bus_region_decoder_with_protection_top
  import brdp_pkg::*;
#(
  parameter int REGION_COUNT    = 16,
  parameter int MAX_ALIAS_DEPTH = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  brdp_req_if.sink   req,
  brdp_rsp_if.source rsp,
  brdp_cfg_if.sink   cfg
);
  localparam int SW = $clog2(REGION_COUNT);
  localparam int HW = $clog2(MAX_ALIAS_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TGT  = 3'd1;
  localparam logic [2:0] S_OVL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  // region table
  logic [REGION_COUNT-1:0] valid_q;
  logic [31:0] base_q  [REGION_COUNT];
  logic [31:0] len_q   [REGION_COUNT];
  logic [2:0]  kind_q  [REGION_COUNT];
  logic [2:0]  perm_q  [REGION_COUNT];
  logic [31:0] abase_q [REGION_COUNT];

  logic [2:0]    state_q;
  logic [SW-1:0] slot_q;
  logic [SW:0]   hit_q;      // msb clear: found slot
  logic [HW-1:0] hops_q;
  logic          trap_q;
  req_t          r_q;
  logic [31:0]   addr_q;
  logic [31:0]   wlen_q;     // access width or mapped length
  logic [2:0]    rights_q;
  rsp_t          out_q;

  assign req.ready = (state_q == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = (state_q == S_RESP);
  assign rsp.data  = out_q;

  // shared compare unit on the current slot
  logic [32:0] s_end, q_end, lo, hi;
  logic        s_hit, s_hold, s_ovl, last;
  logic [31:0] sbase;
  always_comb begin
    sbase  = base_q[slot_q];
    s_end  = {1'b0, sbase} + {1'b0, len_q[slot_q]};
    q_end  = {1'b0, addr_q} + {1'b0, wlen_q};
    s_hit  = valid_q[slot_q] && addr_q >= sbase && {1'b0, addr_q} < s_end;
    s_hold = addr_q >= sbase && q_end <= s_end;
    lo     = (addr_q > sbase) ? {1'b0, addr_q} : {1'b0, sbase};
    hi     = (q_end < s_end) ? q_end : s_end;
    s_ovl  = valid_q[slot_q] && lo < hi;
    last   = (slot_q == SW'(REGION_COUNT - 1));
  end

  function automatic logic span_ok(logic [31:0] b, logic [31:0] l);
    return l != 32'd0 && b <= (32'hFFFF_FFFF - (l - 32'd1));
  endfunction

  logic [31:0] off;
  assign off = addr_q - sbase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      trap_q  <= 1'b0;
      slot_q  <= '0;
      hit_q   <= '0;
      hops_q  <= '0;
    end else begin
      if (cfg.valid) trap_q <= cfg.data;
      case (state_q)
        S_IDLE: if (req.valid) begin
          r_q    <= req.data;
          slot_q <= '0;
          hops_q <= '0;
          hit_q  <= {1'b1, SW'(0)};
          out_q  <= '0;
          state_q <= S_RESP;
          if (req.data.opcode == OP_MAP) begin
            if (req.data.region_kind > KIND_MAX) out_q.fault <= F_BADRANGE;
            else if (req.data.region_kind == KIND_ALIAS) begin
              if (!span_ok(req.data.alias_dest, req.data.region_size))
                out_q.fault <= F_BADALIAS;
              else begin
                addr_q <= req.data.alias_dest;
                wlen_q <= req.data.region_size;
                state_q <= S_TGT;
              end
            end else if (!span_ok(req.data.address, req.data.region_size))
              out_q.fault <= F_BADRANGE;
            else begin
              rights_q <= req.data.region_perms;
              addr_q <= req.data.address;
              wlen_q <= req.data.region_size;
              state_q <= S_OVL;
            end
          end else if (req.data.opcode == OP_READ || req.data.opcode == OP_WRITE) begin
            addr_q <= req.data.address;
            wlen_q <= 32'd1 << req.data.access_size;
            state_q <= S_ACC;
          end
        end
        // find the region holding the alias target
        S_TGT: begin
          if (s_hit) begin
            if (!s_hold) begin
              out_q.fault <= F_BADALIAS;
              state_q <= S_RESP;
            end else if (!span_ok(r_q.address, r_q.region_size)) begin
              out_q.fault <= F_BADRANGE;
              state_q <= S_RESP;
            end else begin
              rights_q <= perm_q[slot_q];
              addr_q <= r_q.address;
              slot_q <= '0;
              state_q <= S_OVL;
            end
          end else if (last) begin
            out_q.fault <= F_BADALIAS;
            state_q <= S_RESP;
          end else slot_q <= slot_q + SW'(1);
        end
        // overlap scan and free slot search
        S_OVL: begin
          if (s_ovl) begin
            out_q.fault <= F_OVERLAP;
            state_q <= S_RESP;
          end else begin
            if (!valid_q[slot_q] && hit_q[SW]) hit_q <= {1'b0, slot_q};
            if (last) begin
              if (hit_q[SW] && valid_q[slot_q]) out_q.fault <= F_FULL;
              else begin : commit
                logic [SW-1:0] fs;
                fs = hit_q[SW] ? slot_q : hit_q[SW-1:0];
                valid_q[fs] <= 1'b1;
                base_q[fs]  <= r_q.address;
                len_q[fs]   <= r_q.region_size;
                kind_q[fs]  <= r_q.region_kind;
                perm_q[fs]  <= rights_q;
                abase_q[fs] <= (r_q.region_kind == KIND_ALIAS) ? r_q.alias_dest : 32'd0;
                out_q.region_index <= 4'(fs);
                out_q.final_kind <= r_q.region_kind;
              end
              state_q <= S_RESP;
            end else slot_q <= slot_q + SW'(1);
          end
        end
        // lookup of one hop
        S_ACC: begin
          if (!span_ok(addr_q, wlen_q)) begin
            out_q.fault <= F_WRAP;
            state_q <= S_RESP;
          end else if (s_hit) state_q <= S_CHK;
          else if (last) begin
            out_q.fault <= F_UNMAPPED;
            state_q <= S_RESP;
          end else slot_q <= slot_q + SW'(1);
        end
        // checks on the hit slot
        S_CHK: begin
          state_q <= S_RESP;
          if (!s_hold) out_q.fault <= F_CROSS;
          else if (r_q.opcode == OP_WRITE && !perm_q[slot_q][1]) out_q.fault <= F_WPROT;
          else if (r_q.opcode == OP_READ && !perm_q[slot_q][0]) out_q.fault <= F_RPROT;
          else if (r_q.opcode == OP_READ && r_q.ifetch && !perm_q[slot_q][2])
            out_q.fault <= F_XPROT;
          else if (kind_q[slot_q] == KIND_ALIAS) begin
            if (hops_q == HW'(MAX_ALIAS_DEPTH)) out_q.fault <= F_LOOP;
            else begin
              hops_q <= hops_q + HW'(1);
              addr_q <= abase_q[slot_q] + off;
              slot_q <= '0;
              state_q <= S_ACC;
            end
          end else if (kind_q[slot_q] == KIND_MMIO && trap_q) out_q.fault <= F_MMIO;
          else begin
            out_q.region_index <= 4'(slot_q);
            out_q.offset <= off;
            out_q.final_kind <= kind_q[slot_q];
          end
        end
        S_RESP: if (rsp.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_hops_bound, clk_i, rst_ni, hops_q <= HW'(MAX_ALIAS_DEPTH))
  `ASSERT_IMPL(a_busy, clk_i, rst_ni, !(req.ready && rsp.valid))
  `ASSERT_ALWAYS(a_ok_fields, clk_i, rst_ni,
    !(rsp.valid && rsp.data.fault != F_OK) || (rsp.data.offset == 32'd0))
endmodule
`default_nettype wire
